// ----- rtl/tlbfl_pkg.sv -----
`default_nettype none

package tlbfl_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int PID_W       = 16;
  localparam int PAGE_W      = 20;
  localparam int FRAME_W     = 20;
  localparam int COUNT_W     = 21;
  localparam int TYPE_W      = 2;
  localparam int KIND_W      = 2;
  localparam int CFG_CNT_W   = 5;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // request types
  localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FILL   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_TRUNC  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_HIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MISS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TRUNC = 2'd3;

  // replacement modes
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_ENTRIES = 1'b1;

  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [PID_W-1:0]   wr_pid;
    logic [PAGE_W-1:0]  wr_page;
    logic [FRAME_W-1:0] wr_frame;
    logic               inv_en;
    logic [IDX_W-1:0]   inv_idx;
    logic               promote_en;
    logic [IDX_W-1:0]   promote_idx;
    logic [IDX_W-1:0]   promote_rank;
  } store_cmd_t;

  typedef struct packed {
    logic               valid;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic [IDX_W-1:0]   rank;
  } store_rd_t;

endpackage

`default_nettype wire

// ----- rtl/tlbfl_req_if.sv -----
`default_nettype none

interface tlbfl_req_if import tlbfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [PID_W-1:0]   pid;
  logic [PAGE_W-1:0]  page;
  logic [FRAME_W-1:0] fill_frame;
  logic [COUNT_W-1:0] page_count;

  modport source (output valid, req_type, pid, page, fill_frame, page_count, input ready);
  modport sink (input valid, req_type, pid, page, fill_frame, page_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/tlbfl_rsp_if.sv -----
`default_nettype none

interface tlbfl_rsp_if import tlbfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [FRAME_W-1:0] result_frame;
  logic [PID_W-1:0]   req_pid;
  logic [PAGE_W-1:0]  req_page;

  modport source (output valid, result_kind, result_frame, req_pid, req_page, input ready);
  modport sink (input valid, result_kind, result_frame, req_pid, req_page, output ready);
endinterface

`default_nettype wire

// ----- rtl/tlb_fifo_lru_lookup.sv -----
// Operation: a lookup scans the entries in use until a hit, plus the LRU rank update
//   on a hit; a fill writes the FIFO pointer's entry (FIFO) or scans for the lowest rank (LRU).
// A truncate scans all 16 entries. With no entries in use, lookup and fill skip the scan.
// Throughput: one item at a time; next accept follows the output register load.
// Reset: synchronous, active high; clears valid bits and FIFO pointer, restores
//   rank order (entry 0 oldest), FIFO mode and 16 entries in use.
`default_nettype none

module tlb_fifo_lru_lookup import tlbfl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  tlbfl_req_if.sink                  req,
  tlbfl_rsp_if.source                rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_WRITE   = 5'b00100,
    S_PROMOTE = 5'b01000,
    S_FINISH  = 5'b10000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic                 mode;
  logic [CFG_CNT_W-1:0] entries_in_use;

  // latched request
  logic [TYPE_W-1:0]  op;
  logic [PID_W-1:0]   r_pid;
  logic [PAGE_W-1:0]  r_page;
  logic [FRAME_W-1:0] r_frame;
  logic [COUNT_W-1:0] r_count;

  // sequencer registers
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [IDX_W-1:0]   victim, victim_next;
  logic [IDX_W-1:0]   best_rank, best_rank_next;
  logic [IDX_W-1:0]   fifo_next, fifo_next_next;
  logic [KIND_W-1:0]  res_kind, res_kind_next;
  logic [FRAME_W-1:0] res_frame, res_frame_next;

  // output register
  logic               o_valid;
  logic [KIND_W-1:0]  o_kind;
  logic [FRAME_W-1:0] o_frame;
  logic [PID_W-1:0]   o_pid;
  logic [PAGE_W-1:0]  o_page;

  logic [CNT_W-1:0]   n_act;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   fifo_victim;
  logic               in_beat;
  logic               out_load;
  logic               cnt_last;
  logic               hit;
  logic               trunc_match;
  logic               rank_better;
  store_cmd_t         cmd;
  store_rd_t          rd;

  // ---------------------------------------------------------------------------
  // APB configuration port: writes land in the access phase, reads are direct.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_FIFO;
      entries_in_use <= CFG_CNT_W'(MAX_ENTRIES);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_MODE:    mode           <= pwdata[0];
        REG_ENTRIES: entries_in_use <= pwdata[CFG_CNT_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE:    prdata = {{(APB_DATA_W-1){1'b0}}, mode};
      REG_ENTRIES: prdata = {{(APB_DATA_W-CFG_CNT_W){1'b0}}, entries_in_use};
      default:     prdata = '0;
    endcase
  end

  // Saturate the entry count to the table size.
  assign n_act = (entries_in_use > CFG_CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                           : CNT_W'(entries_in_use);

  // FIFO pointer beyond the count in use restarts at entry 0.
  assign fifo_victim = ({1'b0, fifo_next} < n_act) ? fifo_next : '0;

  // ---------------------------------------------------------------------------
  // Shared compare unit: looks at one entry per cycle, the one under cnt.
  // ---------------------------------------------------------------------------
  assign idx         = cnt[IDX_W-1:0];
  assign hit         = rd.valid && (rd.pid == r_pid) && (rd.page == r_page);
  assign trunc_match = rd.valid && (rd.pid == r_pid) && (COUNT_W'(rd.page) >= r_count);
  assign rank_better = (cnt == '0) || (rd.rank < best_rank);

  // Truncate sweeps every stored entry; lookup and LRU fill sweep the entries in use.
  assign cnt_last = (op == REQ_TRUNC) ? (cnt == CNT_W'(MAX_ENTRIES - 1))
                                      : (cnt == n_act - 1'b1);

  assign in_beat  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_load = (state == S_FINISH) && (!o_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (in_beat) begin
      op      <= req.req_type;
      r_pid   <= req.pid;
      r_page  <= req.page;
      r_frame <= req.fill_frame;
      r_count <= req.page_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    victim_next    = victim;
    best_rank_next = best_rank;
    fifo_next_next = fifo_next;
    res_kind_next  = res_kind;
    res_frame_next = res_frame;

    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_beat) begin
          unique case (req.req_type)
            REQ_LOOKUP: begin
              // With nothing in use every lookup misses at once.
              res_kind_next  = KIND_MISS;
              res_frame_next = '0;
              state_next     = (n_act == '0) ? S_FINISH : S_SCAN;
            end
            REQ_FILL: begin
              res_kind_next  = KIND_FILL;
              res_frame_next = req.fill_frame;
              if (n_act == '0) begin
                state_next = S_FINISH;
              end else if (mode == MODE_FIFO) begin
                victim_next = fifo_victim;
                fifo_next_next = (CNT_W'(fifo_victim) + 1'b1 == n_act) ? '0
                                                                       : fifo_victim + 1'b1;
                state_next = S_WRITE;
              end else begin
                state_next = S_SCAN;
              end
            end
            REQ_TRUNC: begin
              res_kind_next  = KIND_TRUNC;
              res_frame_next = '0;
              state_next     = S_SCAN;
            end
            default: ; // unused type: drop the beat, no result
          endcase
        end
      end

      S_SCAN: begin
        cnt_next = cnt + 1'b1;
        unique case (op)
          REQ_LOOKUP: begin
            if (hit) begin
              res_kind_next  = KIND_HIT;
              res_frame_next = rd.frame;
              victim_next    = idx;
              best_rank_next = rd.rank;
              state_next     = (mode == MODE_LRU) ? S_PROMOTE : S_FINISH;
            end else if (cnt_last) begin
              state_next = S_FINISH;
            end
          end
          REQ_FILL: begin
            // Track the lowest rank; the lowest index wins a tie.
            if (rank_better) begin
              victim_next    = idx;
              best_rank_next = rd.rank;
            end
            if (cnt_last) begin
              state_next = S_WRITE;
            end
          end
          default: begin
            if (cnt_last) begin
              state_next = S_FINISH;
            end
          end
        endcase
      end

      S_WRITE:   state_next = S_FINISH;
      S_PROMOTE: state_next = S_FINISH;

      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      fifo_next <= '0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      fifo_next <= fifo_next_next;
    end
  end

  always_ff @(posedge clk) begin
    victim    <= victim_next;
    best_rank <= best_rank_next;
    res_kind  <= res_kind_next;
    res_frame <= res_frame_next;
  end

  // ---------------------------------------------------------------------------
  // Entry store commands
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd.wr_en        = (state == S_WRITE);
    cmd.wr_idx       = victim;
    cmd.wr_pid       = r_pid;
    cmd.wr_page      = r_page;
    cmd.wr_frame     = r_frame;
    cmd.inv_en       = (state == S_SCAN) && (op == REQ_TRUNC) && trunc_match;
    cmd.inv_idx      = idx;
    cmd.promote_en   = (state == S_PROMOTE) || ((state == S_WRITE) && (mode == MODE_LRU));
    cmd.promote_idx  = victim;
    cmd.promote_rank = best_rank;
  end

  tlbfl_store u_store (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .rd_idx (idx),
    .rd     (rd)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold the beat until the sink takes it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_kind  <= res_kind;
      o_frame <= res_frame;
      o_pid   <= (res_kind == KIND_MISS) ? r_pid : '0;
      o_page  <= (res_kind == KIND_MISS) ? r_page : '0;
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.result_kind  = o_kind;
  assign rsp.result_frame = o_frame;
  assign rsp.req_pid      = o_pid;
  assign rsp.req_page     = o_page;

`ifndef ASSERT_OFF
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat && (req.req_type == REQ_LOOKUP) |=> !req.ready)
    else $error("lookup accepted but block still ready");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cnt < CNT_W'(MAX_ENTRIES)))
    else $error("scan counter ran past the table");

  a_write_needs_entries: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (n_act != '0))
    else $error("fill write with no entries in use");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    o_valid && !rsp.ready |-> !out_load)
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- rtl/tlbfl_store.sv -----
`default_nettype none

module tlbfl_store import tlbfl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire store_cmd_t       cmd,
  input  wire logic [IDX_W-1:0] rd_idx,
  output store_rd_t             rd
);

  logic [MAX_ENTRIES-1:0] valid;
  logic [PID_W-1:0]       pid_mem   [MAX_ENTRIES];
  logic [PAGE_W-1:0]      page_mem  [MAX_ENTRIES];
  logic [FRAME_W-1:0]     frame_mem [MAX_ENTRIES];
  logic [IDX_W-1:0]       rank      [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.wr_en) begin
        valid[cmd.wr_idx] <= 1'b1;
      end
      if (cmd.inv_en) begin
        valid[cmd.inv_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      pid_mem[cmd.wr_idx]   <= cmd.wr_pid;
      page_mem[cmd.wr_idx]  <= cmd.wr_page;
      frame_mem[cmd.wr_idx] <= cmd.wr_frame;
    end
  end

  // Move the promoted entry to the top; close the gap it leaves.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (rst) begin
        rank[i] <= IDX_W'(i);
      end else if (cmd.promote_en) begin
        if (IDX_W'(i) == cmd.promote_idx) begin
          rank[i] <= IDX_W'(MAX_ENTRIES - 1);
        end else if (rank[i] > cmd.promote_rank) begin
          rank[i] <= rank[i] - 1'b1;
        end
      end
    end
  end

  always_comb begin
    rd.valid = valid[rd_idx];
    rd.pid   = pid_mem[rd_idx];
    rd.page  = page_mem[rd_idx];
    rd.frame = frame_mem[rd_idx];
    rd.rank  = rank[rd_idx];
  end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top import tlbfl_pkg::*; ();

  // Request type with no meaning to the block: it takes the beat and answers nothing.
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  // Settle well past the longest block operation (LRU fill or hit, or a truncate scan)
  // before touching the registers or ending the run.
  localparam int SETTLE_CYCLES = 40;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int HOLD_CYCLES   = 300;
  // About 1500 beats, each slowed by the block scan, sender gaps and receiver stalls,
  // plus phase settling and the hold-off, then several times over.
  localparam int CYCLE_LIMIT   = 600000;
  localparam int NUM_PHASES    = 12;

  typedef struct packed {
    logic [TYPE_W-1:0]  req_type;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] fill_frame;
    logic [COUNT_W-1:0] page_count;
  } tlb_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [FRAME_W-1:0] result_frame;
    logic [PID_W-1:0]   req_pid;
    logic [PAGE_W-1:0]  req_page;
  } tlb_rsp_t;

  typedef struct {
    tlb_req_t item;
    bit       fixed;
    tlb_rsp_t want;
  } stim_row_t;

  // Register settings per phase; extremes include zero entries and a count above
  // the table size, which must saturate to all sixteen entries.
  logic phase_mode [NUM_PHASES] = '{MODE_FIFO, MODE_LRU, MODE_FIFO, MODE_LRU,
                                    MODE_FIFO, MODE_LRU, MODE_FIFO, MODE_LRU,
                                    MODE_FIFO, MODE_LRU, MODE_FIFO, MODE_LRU};
  int   phase_entries [NUM_PHASES] = '{16, 16, 3, 31, 0, 0, 1, 1, 16, 7, 31, 16};
  int   phase_items   [NUM_PHASES] = '{110, 150, 120, 150, 60, 60, 100, 100,
                                       150, 150, 150, 140};

  logic clk = 1'b0;
  logic rst;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tlbfl_req_if req_bus ();
  tlbfl_rsp_if rsp_bus ();

  tlb_fifo_lru_lookup i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow TLB: the contents, replacement state and register copies that the
  // expected results are worked out from.
  // ---------------------------------------------------------------------------
  logic               shadow_valid [MAX_ENTRIES];
  logic [PID_W-1:0]   shadow_pid   [MAX_ENTRIES];
  logic [PAGE_W-1:0]  shadow_page  [MAX_ENTRIES];
  logic [FRAME_W-1:0] shadow_frame [MAX_ENTRIES];
  logic [IDX_W-1:0]   shadow_rank  [MAX_ENTRIES];
  int                 fifo_ptr;
  logic               cfg_mode;
  logic [CFG_CNT_W-1:0] cfg_entries;

  tlb_rsp_t pending_results [$];
  int       err_count;
  int       cycle_cnt;
  int       kind_seen [4];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_toggle;

  // Marks the beat on the request channel whose answer is typed into the table.
  bit       drv_fixed;
  tlb_rsp_t drv_expect;

  logic [PID_W-1:0]  pid_pool [3];
  logic [PAGE_W-1:0] page_base;

  initial begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_pid[i]   = '0;
      shadow_page[i]  = '0;
      shadow_frame[i] = '0;
      shadow_rank[i]  = IDX_W'(i);  // entry 0 is the oldest after reset
    end
    fifo_ptr    = 0;
    cfg_mode    = MODE_FIFO;
    cfg_entries = CFG_CNT_W'(16);
  end

  // Make entry e the most recent; every rank above its old one drops by one.
  function automatic void promote(input int e);
    logic [IDX_W-1:0] old_rank;
    old_rank = shadow_rank[e];
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (shadow_rank[i] > old_rank) shadow_rank[i] = shadow_rank[i] - 1'b1;
    shadow_rank[e] = IDX_W'(MAX_ENTRIES - 1);
  endfunction

  // Advance the shadow TLB by one request; return 1 when the request has an answer.
  function automatic bit predict_tlb(input tlb_req_t r, output tlb_rsp_t o);
    int n;
    int victim;
    n = (cfg_entries > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_entries);
    o = '0;
    case (r.req_type)
      REQ_LOOKUP: begin
        // lowest matching index wins when a page sits in more than one entry
        for (int i = 0; i < n; i++) begin
          if (shadow_valid[i] && shadow_pid[i] == r.pid && shadow_page[i] == r.page) begin
            o.result_kind  = KIND_HIT;
            o.result_frame = shadow_frame[i];
            if (cfg_mode == MODE_LRU) promote(i);
            return 1'b1;
          end
        end
        o.result_kind = KIND_MISS;
        o.req_pid     = r.pid;
        o.req_page    = r.page;
      end
      REQ_FILL: begin
        // with no entries in use the fill is answered but stores nothing
        if (n > 0) begin
          if (cfg_mode == MODE_FIFO) begin
            // a pointer left beyond a shrunken table restarts at entry 0
            victim   = (fifo_ptr < n) ? fifo_ptr : 0;
            fifo_ptr = (victim + 1) % n;
          end else begin
            // least recent entry in use, valid or not
            victim = 0;
            for (int i = 1; i < n; i++)
              if (shadow_rank[i] < shadow_rank[victim]) victim = i;
            promote(victim);
          end
          shadow_valid[victim] = 1'b1;
          shadow_pid[victim]   = r.pid;
          shadow_page[victim]  = r.page;
          shadow_frame[victim] = r.fill_frame;
        end
        o.result_kind  = KIND_FILL;
        o.result_frame = r.fill_frame;
      end
      REQ_TRUNC: begin
        // every stored entry, in use or not; ranks and pointer stay put
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (shadow_valid[i] && shadow_pid[i] == r.pid &&
              COUNT_W'(shadow_page[i]) >= r.page_count)
            shadow_valid[i] = 1'b0;
        o.result_kind = KIND_TRUNC;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Print one line per mismatch and count.
  task automatic report_err(input string msg);
    err_count++;
    $display("ERROR cycle %0d: %s", cycle_cnt, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Cycle counter and timeout.
  // ---------------------------------------------------------------------------
  initial cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check answered beats first, then predict the accepted request, so a
  // request and an older answer on the same edge stay in order.
  // ---------------------------------------------------------------------------
  initial begin
    err_count = 0;
    for (int k = 0; k < 4; k++) kind_seen[k] = 0;
  end

  always @(posedge clk) begin
    tlb_rsp_t got;
    tlb_rsp_t want;
    tlb_req_t taken;
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.result_kind  = rsp_bus.result_kind;
        got.result_frame = rsp_bus.result_frame;
        got.req_pid      = rsp_bus.req_pid;
        got.req_page     = rsp_bus.req_page;
        if (pending_results.size() == 0) begin
          report_err($sformatf("result kind %0d with nothing pending", got.result_kind));
        end else begin
          want = pending_results.pop_front();
          kind_seen[got.result_kind]++;
          if (got.result_kind !== want.result_kind)
            report_err($sformatf("result_kind %0d, want %0d",
                                 got.result_kind, want.result_kind));
          if (got.result_frame !== want.result_frame)
            report_err($sformatf("result_frame %05h, want %05h",
                                 got.result_frame, want.result_frame));
          if (got.req_pid !== want.req_pid)
            report_err($sformatf("req_pid %04h, want %04h", got.req_pid, want.req_pid));
          if (got.req_page !== want.req_page)
            report_err($sformatf("req_page %05h, want %05h", got.req_page, want.req_page));
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        taken.req_type   = req_bus.req_type;
        taken.pid        = req_bus.pid;
        taken.page       = req_bus.page;
        taken.fill_frame = req_bus.fill_frame;
        taken.page_count = req_bus.page_count;
        // table rows with a typed answer still advance the shadow TLB
        if (predict_tlb(taken, want))
          pending_results.push_back(drv_fixed ? drv_expect : want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here on request.
  // ---------------------------------------------------------------------------
  initial begin
    bit hold_seen;
    hold_seen     = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        rsp_bus.ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register access.
  // ---------------------------------------------------------------------------

  // Offer one beat and hold it until taken; valid only drops when a gap is drawn.
  task automatic offer(input tlb_req_t it, input bit fixed, input tlb_rsp_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= it.req_type;
    req_bus.pid        <= it.pid;
    req_bus.page       <= it.page;
    req_bus.fill_frame <= it.fill_frame;
    req_bus.page_count <= it.page_count;
    drv_fixed          <= fixed;
    drv_expect         <= want;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Wait out every pending answer, then the block's longest latency, so that
  // even an unanswered beat has left the pipeline.
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup then access; the register takes the value on the access edge.
  task automatic apb_write(input logic reg_idx, input logic [APB_DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_idx == REG_MODE) cfg_mode = val[0];
    else cfg_entries = val[CFG_CNT_W-1:0];
  endtask

  function automatic logic [PID_W-1:0] pick_pid();
    if ($urandom_range(15) == 0) return PID_W'($urandom);
    return pid_pool[$urandom_range(2)];
  endfunction

  function automatic logic [PAGE_W-1:0] pick_page();
    if ($urandom_range(15) == 0) return PAGE_W'($urandom);
    return page_base + PAGE_W'($urandom_range(11));
  endfunction

  // Mostly miss-then-fill pairs over a few processes and a dozen pages so that
  // hits, evictions and truncates keep meeting each other; the rest is noise.
  task automatic run_random(input int n_items);
    tlb_req_t it;
    int       done;
    int       sel;
    done = 0;
    while (done < n_items) begin
      it.req_type   = REQ_LOOKUP;
      it.pid        = pick_pid();
      it.page       = pick_page();
      it.fill_frame = FRAME_W'($urandom);
      it.page_count = COUNT_W'($urandom_range(1048576));
      sel = $urandom_range(99);
      if (sel < 4) begin
        it.req_type = REQ_UNUSED;
        offer(it, 1'b0, '0);
      end else if (sel < 64) begin
        offer(it, 1'b0, '0);
        done++;
        // answer the lookup with the fill a miss would ask for
        if ($urandom_range(99) < 70) begin
          it.req_type   = REQ_FILL;
          it.fill_frame = FRAME_W'($urandom);
          offer(it, 1'b0, '0);
          done++;
        end
      end else if (sel < 76) begin
        it.req_type = REQ_FILL;
        offer(it, 1'b0, '0);
        done++;
      end else if (sel < 88) begin
        it.pid = PID_W'($urandom);
        offer(it, 1'b0, '0);
        done++;
      end else begin
        it.req_type = REQ_TRUNC;
        case ($urandom_range(9))
          0:       it.page_count = '0;
          1:       it.page_count = COUNT_W'(1048576);
          2:       it.page_count = COUNT_W'($urandom_range(1048576));
          default: it.page_count = COUNT_W'(page_base) + COUNT_W'($urandom_range(12));
        endcase
        offer(it, 1'b0, '0);
        done++;
      end
    end
  endtask

  function automatic stim_row_t stim_row(
    input logic [TYPE_W-1:0] t, input logic [PID_W-1:0] p, input logic [PAGE_W-1:0] pg,
    input logic [FRAME_W-1:0] fr, input logic [COUNT_W-1:0] cnt, input bit fixed,
    input logic [KIND_W-1:0] wk, input logic [FRAME_W-1:0] wf,
    input logic [PID_W-1:0] wp, input logic [PAGE_W-1:0] wpg);
    stim_row_t r;
    r.item  = '{req_type: t, pid: p, page: pg, fill_frame: fr, page_count: cnt};
    r.fixed = fixed;
    r.want  = '{result_kind: wk, result_frame: wf, req_pid: wp, req_page: wpg};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t directed_rows [$];

    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_LOOKUP;
    req_bus.pid        = '0;
    req_bus.page       = '0;
    req_bus.fill_frame = '0;
    req_bus.page_count = '0;
    drv_fixed          = 1'b0;
    drv_expect         = '0;
    hold_toggle        = 1'b0;
    send_idle_pct      = 34;
    recv_idle_pct      = 50;

    // Directed rows at the reset setting (FIFO, all sixteen entries). A set
    // fixed flag means the answer is typed in; the others go to the predictor.
    //                         type        pid       page      frame     count    fx kind
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 21'h0,
                                     1, KIND_MISS, 20'h00000, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_FILL,   16'h0000, 20'h00000, 20'h00000, 21'h0,
                                     1, KIND_FILL, 20'h00000, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 21'h0,
                                     1, KIND_HIT,  20'h00000, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000, 21'h0,
                                     1, KIND_MISS, 20'h00000, 16'hFFFF, 20'hFFFFF));
    directed_rows.push_back(stim_row(REQ_FILL,   16'hFFFF, 20'hFFFFF, 20'hFFFFF, 21'h0,
                                     1, KIND_FILL, 20'hFFFFF, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000, 21'h0,
                                     1, KIND_HIT,  20'hFFFFF, 16'h0000, 20'h00000));
    // same page under another process, and the other way round
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'hFFFF, 20'h00000, 20'h00000, 21'h0,
                                     1, KIND_MISS, 20'h00000, 16'hFFFF, 20'h00000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 20'hFFFFF, 20'h00000, 21'h0,
                                     1, KIND_MISS, 20'h00000, 16'h0000, 20'hFFFFF));
    // duplicate of an existing page in a higher entry: the lower one must win
    directed_rows.push_back(stim_row(REQ_FILL,   16'h0000, 20'h00000, 20'h5A5A5, 21'h0,
                                     1, KIND_FILL, 20'h5A5A5, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 21'h0,
                                     0, KIND_HIT,  20'h00000, 16'h0000, 20'h00000));
    // unused type: dropped without an answer
    directed_rows.push_back(stim_row(REQ_UNUSED, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 21'h1FFFFF,
                                     0, KIND_HIT,  20'h00000, 16'h0000, 20'h00000));
    // count past the last page keeps everything, then the top page goes
    directed_rows.push_back(stim_row(REQ_TRUNC,  16'hFFFF, 20'h00000, 20'h00000, 21'h100000,
                                     1, KIND_TRUNC, 20'h00000, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000, 21'h0,
                                     0, KIND_HIT,  20'h00000, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_TRUNC,  16'hFFFF, 20'h00000, 20'h00000, 21'h0FFFFF,
                                     1, KIND_TRUNC, 20'h00000, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'hFFFF, 20'hFFFFF, 20'h00000, 21'h0,
                                     0, KIND_HIT,  20'h00000, 16'h0000, 20'h00000));
    // zero count wipes the process
    directed_rows.push_back(stim_row(REQ_TRUNC,  16'h0000, 20'h00000, 20'h00000, 21'h0,
                                     1, KIND_TRUNC, 20'h00000, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h0000, 20'h00000, 20'h00000, 21'h0,
                                     0, KIND_HIT,  20'h00000, 16'h0000, 20'h00000));
    // boundary: page just below the count survives, page at the count goes
    directed_rows.push_back(stim_row(REQ_FILL,   16'h1234, 20'h00005, 20'hA5A5A, 21'h0,
                                     1, KIND_FILL, 20'hA5A5A, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_TRUNC,  16'h1234, 20'h00000, 20'h00000, 21'h6,
                                     1, KIND_TRUNC, 20'h00000, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h1234, 20'h00005, 20'h00000, 21'h0,
                                     0, KIND_HIT,  20'h00000, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_TRUNC,  16'h1234, 20'h00000, 20'h00000, 21'h5,
                                     1, KIND_TRUNC, 20'h00000, 16'h0000, 20'h00000));
    directed_rows.push_back(stim_row(REQ_LOOKUP, 16'h1234, 20'h00005, 20'h00000, 21'h0,
                                     0, KIND_HIT,  20'h00000, 16'h0000, 20'h00000));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      offer(directed_rows[k].item, directed_rows[k].fixed, directed_rows[k].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      // idle pattern: receiver-heavy gaps, then sender-heavy, then none at all
      send_idle_pct = (ph < 4) ? 34 : (ph < 8) ? 50 : 0;
      recv_idle_pct = (ph < 4) ? 50 : (ph < 8) ? 34 : 0;
      apb_write(REG_MODE, APB_DATA_W'(phase_mode[ph]));
      apb_write(REG_ENTRIES, APB_DATA_W'(phase_entries[ph]));
      foreach (pid_pool[k]) pid_pool[k] = PID_W'($urandom);
      page_base = PAGE_W'($urandom_range(20'hFFFF0));
      // back the block up once: receiver stops while beats keep coming
      if (ph == 1) hold_toggle = ~hold_toggle;
      run_random(phase_items[ph]);
    end
    drain();

    $display("Covered %0d register phases (FIFO and LRU, 0 to 31 entries) with idle mixes",
             NUM_PHASES);
    $display("Answers checked: %0d hits, %0d misses, %0d fills, %0d truncates",
             kind_seen[KIND_HIT], kind_seen[KIND_MISS], kind_seen[KIND_FILL],
             kind_seen[KIND_TRUNC]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
